FILE: sv/keyboard_status_data_device_core_macros.svh
// ---------------------------------------------------------------------------
// Keyboard status/data device - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef KEYBOARD_STATUS_DATA_DEVICE_CORE_MACROS_SVH
`define KEYBOARD_STATUS_DATA_DEVICE_CORE_MACROS_SVH

// plain invariant, checked on every clock edge out of reset
`define KBD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// same-cycle implication
`define KBD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: sv/kbd_pkg.sv
// ---------------------------------------------------------------------------
// Keyboard status/data device - package
// Shared types and codes for the keyboard port core and its cells.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kbd_pkg;

  // item kinds carried on in_tuser
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  // configuration register indexes
  localparam logic CFG_STATUS_ADDR = 1'b0;
  localparam logic CFG_DATA_ADDR   = 1'b1;

  localparam logic [15:0] STATUS_ADDR_RST = 16'hFE00;
  localparam logic [15:0] DATA_ADDR_RST   = 16'hFE02;

  // status register bit positions
  localparam int unsigned READY_BIT = 15;
  localparam int unsigned IE_BIT    = 14;

  // per-cell control from the FIFO controller
  typedef struct packed {
    logic shift;  // pop: take neighbor's key
    logic load;   // push lands in this cell
  } cell_ctl_t;

  // one result item
  typedef struct packed {
    logic        key_dropped;
    logic        key_request;
    logic        poll_notice;
    logic        interrupt_request;
    logic [15:0] read_data;
  } res_t;

endpackage

FILE: sv/kbd_cell.sv
// ---------------------------------------------------------------------------
// Keyboard FIFO cell
// One key slot of the shifting key queue; cell 0 holds the front key.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbd_cell
  import kbd_pkg::*;
(
  input  logic       clk,
  input  cell_ctl_t  ctl,
  input  logic [7:0] push_key,
  input  logic [7:0] next_key,
  output logic [7:0] key
);

  logic [7:0] key_r;
  logic [7:0] key_nxt;

  // a push and a pop never come in the same item
  always_comb begin
    priority if (ctl.load) begin
      key_nxt = push_key;
    end else if (ctl.shift) begin
      key_nxt = next_key;
    end else begin
      key_nxt = key_r;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;

endmodule

FILE: sv/kbd_outbuf.sv
// ---------------------------------------------------------------------------
// Keyboard result buffer
// Two-entry output register with skid slot between core and out channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kbd_outbuf
  import kbd_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_res_r, out_res_nxt;
  res_t skid_res_r, skid_res_nxt;
  logic take;
  logic give;

  assign in_ready = !skid_valid_r;
  assign take     = in_valid && !skid_valid_r;
  assign give     = out_valid_r && out_ready;

  // slot update: skid drains first, keeps item order
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_res_nxt    = out_res_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      if (give) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (take) begin
      if (!out_valid_r || give) begin
        out_res_nxt   = in_res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_res_nxt   = in_res;
        skid_valid_nxt = 1'b1;
      end
    end else if (give) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

FILE: sv/keyboard_status_data_device_core.sv
// ---------------------------------------------------------------------------
// Keyboard status/data device core
// Memory-mapped keyboard port: status and data registers over a key queue.
// ---------------------------------------------------------------------------
//  channel | dir | signals                          | payload
//  in      | in  | in_tvalid/in_tready/in_tdata/tuser | bus access or tick (tuser = kind)
//  out     | out | out_tvalid/out_tready/out_tdata  | one result per item
//  cfg     | in  | cfg_we/cfg_index/cfg_wdata       | status and data addresses
//
//  One item per cycle while in_tready is high; each item's result is registered in the result buffer.
//  The key queue is a row of FIFO_DEPTH shifting cells, cell 0 the front key;
//  a pop shifts every cell toward the front in the same cycle.
//  in_tready drops only while both result slots hold items on a stalled out side.
//  Reset (rst_n low, synchronous) empties the queue at once; no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyboard_status_data_device_core_macros.svh"

module keyboard_status_data_device_core
  import kbd_pkg::*;
#(
  parameter int unsigned FIFO_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [15:0] address, [31:16] write_value, [32] key_valid, [40:33] key_code,
  // [41] source_has_more, [47:42] zero
  input  logic [47:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [15:0] read_data, [16] interrupt_request, [17] poll_notice,
  // [18] key_request, [19] key_dropped, [23:20] zero
  output logic [23:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

  // input fields
  act_t        act;
  logic [15:0] addr;
  logic [15:0] wval;
  logic        kvalid;
  logic [7:0]  kcode;
  logic        more;

  assign act    = act_t'(in_tuser);
  assign addr   = in_tdata[15:0];
  assign wval   = in_tdata[31:16];
  assign kvalid = in_tdata[32];
  assign kcode  = in_tdata[40:33];
  assign more   = in_tdata[41];

  // state
  logic [15:0]      stat_addr_r;
  logic [15:0]      data_addr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ready_r, ready_nxt;
  logic             ie_r, ie_nxt;
  logic [7:0]       latch_r, latch_nxt;
  logic             fs_r, fs_nxt;

  logic       acc;
  logic       buf_ready;
  logic       push;
  logic       pop;
  logic       hit_stat;
  logic       hit_data;
  logic       not_full;
  logic [7:0] front_key;
  res_t       res;
  res_t       out_res;

  logic [7:0] cell_key [FIFO_DEPTH];

  assign in_tready = buf_ready;
  assign acc       = in_tvalid && buf_ready;
  assign hit_stat  = (addr == stat_addr_r);
  assign hit_data  = !hit_stat && (addr == data_addr_r);
  assign not_full  = (cnt_r != CNT_FULL);
  // empty queue with a push: the new key is the front
  assign front_key = (cnt_r == '0) ? kcode : cell_key[0];

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_addr_r <= STATUS_ADDR_RST;
      data_addr_r <= DATA_ADDR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STATUS_ADDR: stat_addr_r <= cfg_wdata;
        CFG_DATA_ADDR:   data_addr_r <= cfg_wdata;
        default:         stat_addr_r <= stat_addr_r;
      endcase
    end
  end

  // item decode: register update and result
  always_comb begin
    ready_nxt = ready_r;
    ie_nxt    = ie_r;
    latch_nxt = latch_r;
    fs_nxt    = fs_r;
    push      = 1'b0;
    pop       = 1'b0;
    res       = '0;
    if (acc) begin
      unique case (act)
        ACT_READ: begin
          if (hit_stat) begin
            res.read_data[READY_BIT] = ready_r;
            res.read_data[IE_BIT]    = ie_r;
            res.poll_notice          = 1'b1;
          end else if (hit_data) begin
            res.read_data = {8'h00, latch_r};
            if (ready_r) begin
              ready_nxt = 1'b0;
              if (cnt_r != '0) begin
                pop    = 1'b1;
                fs_nxt = 1'b0;
              end
            end else if (!more) begin
              res.key_request = 1'b1;
            end
          end
        end
        ACT_WRITE: begin
          if (hit_stat) begin
            ie_nxt    = wval[IE_BIT];
            ready_nxt = 1'b0;
          end
        end
        ACT_TICK: begin
          push            = kvalid && not_full;
          res.key_dropped = kvalid && !not_full;
          if ((cnt_r != '0) || push) begin
            ready_nxt = 1'b1;
            latch_nxt = front_key;
            if (!fs_r && ie_r) begin
              fs_nxt                = 1'b1;
              res.interrupt_request = 1'b1;
            end
          end
        end
        default: begin
          res = '0;
        end
      endcase
    end
  end

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      ready_r <= 1'b0;
      ie_r    <= 1'b0;
      latch_r <= 8'h00;
      fs_r    <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      ready_r <= ready_nxt;
      ie_r    <= ie_nxt;
      latch_r <= latch_nxt;
      fs_r    <= fs_nxt;
    end
  end

  // key queue: row of shifting cells
  for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
    cell_ctl_t  ctl;
    logic [7:0] nbr_key;

    assign ctl.shift = pop;
    assign ctl.load  = push && (cnt_r == CNT_W'(i));

    if (i == FIFO_DEPTH - 1) begin : g_last
      assign nbr_key = 8'h00;
    end else begin : g_mid
      assign nbr_key = cell_key[i+1];
    end

    kbd_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .push_key (kcode),
      .next_key (nbr_key),
      .key      (cell_key[i])
    );
  end

  // result buffer
  kbd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (acc),
    .in_ready  (buf_ready),
    .in_res    (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {4'h0, out_res};

  // checks
  `KBD_ASSERT(a_cnt_range, cnt_r <= CNT_FULL, "key count beyond queue depth")
  `KBD_ASSERT_IMP(a_ready_has_key, ready_r, cnt_r != '0, "ready set with empty queue")
  `KBD_ASSERT_IMP(a_fs_has_key, fs_r, cnt_r != '0, "front interrupt mark with empty queue")
  `KBD_ASSERT_IMP(a_no_push_pop, acc, !(push && pop), "push and pop in one item")

endmodule
